@@ hw/rtl/lphs_pkg.sv @@
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the linear-probing hash set: request and
// response payloads, bucket entry layout, request kinds and status codes.
// ----------------------------------------------------------------------------
package lphs_pkg;

  // Default geometry and register reset
  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
  localparam int unsigned KEY_W               = 32;
  localparam int unsigned COUNT_W             = 9;
  localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 9'd192;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERLOAD = 2'd3
  } status_t;

  // Bucket marks; the fourth code is never written
  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_TOMB     = 2'd2
  } mark_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_COMMIT,
    S_CLEAR
  } state_t;

  // One bucket as held in the table memory
  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] item;
  } entry_t;

  // Input request payload
  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] item_key;
    logic [KEY_W-1:0] hash_value;
  } in_req_t;

  // Result payload
  typedef struct packed {
    status_t            status;
    logic               found;
    logic [KEY_W-1:0]   item_out;
    logic [COUNT_W-1:0] used_now;
  } out_rsp_t;

endpackage

@@ hw/rtl/linear_probe_hash_set_core.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Open-addressing hash set with linear probing and tombstones, built around
// a single-port-read bucket memory.
// ----------------------------------------------------------------------------
// A request is put, get, remove or clear, with a 32-bit key and its hash.
// The probe starts at hash mod TABLE_DEPTH and reads one bucket per cycle
// from the bucket memory, reads being issued ahead so the read latency is
// paid once per request. An accepted request goes from idle to the probe,
// which stops at the first bucket that decides or once the whole table has
// been checked on a crowded table, then to the commit step that loads the
// output register, and back to idle. When TABLE_DEPTH is not a power of two
// the hash is first reduced by a reciprocal multiplication, in a reduction
// step ahead of the probe. A clear walks the whole memory, one bucket a
// cycle, then commits its result. After reset the same pass runs over every
// bucket with in_ready low. One request is in flight at a time; a finished
// result sits in the output register, and the next request may be accepted
// while it waits. A result that finds the output register still full holds
// the sequencer in its commit step until out_ready frees the register.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_core #(
  parameter int unsigned TABLE_DEPTH = lphs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lphs_pkg::in_req_t               in_req,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output lphs_pkg::out_rsp_t              out_rsp,
  // configuration
  input  logic                            cfg_we,
  input  logic [lphs_pkg::COUNT_W-1:0]    cfg_wdata
);

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam bit          IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TABLE_DEPTH);
  localparam int unsigned KW = lphs_pkg::KEY_W;
  localparam int unsigned CW = lphs_pkg::COUNT_W;
  localparam int unsigned RECIP_SH = KW + IDX_W;
  // floor(2^RECIP_SH / depth) + 1 gives the exact quotient for any 32-bit hash
  localparam logic [KW:0]   RECIP_M = (KW+1)'(((65'd1 << RECIP_SH) / TABLE_DEPTH) + 1);
  localparam logic [KW-1:0] DEPTH_K = KW'(TABLE_DEPTH);

  // Sequencer
  lphs_pkg::state_t state_r, state_nxt;

  // Request held for the duration of the work
  lphs_pkg::kind_t  kind_r;
  logic [KW-1:0]    key_r;
  logic [KW-1:0]    hash_r;

  // Hash reduction by reciprocal multiplication
  logic             mod_step_r;
  logic [KW-1:0]    quot_r;
  logic [2*KW:0]    mod_prod;
  logic [KW-1:0]    mod_rem;

  // Probe issue and check side
  logic [IDX_W-1:0] iss_pos_r;
  logic [CNT_W-1:0] iss_cnt_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_pos_r;
  logic [IDX_W-1:0] chk_cnt_r;
  logic             tomb_seen_r;
  logic [IDX_W-1:0] tomb_pos_r;

  // Probe outcome
  logic [IDX_W-1:0] slot_r;
  logic             hit_r;
  logic             slot_tomb_r;
  logic             none_r;

  // Counters and configuration
  logic [CW-1:0] used_count_r, used_count_nxt;
  logic [CW-1:0] tomb_count_r, tomb_count_nxt;
  logic [CW-1:0] load_limit_r;
  logic          cnt_upd;

  // Clearing sweep
  logic [IDX_W-1:0] sweep_pos_r;
  logic             sweep_last;

  // Output register
  logic               out_valid_r;
  lphs_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;
  logic               out_free;
  logic               out_load;

  // Memory ports
  logic             rd_en;
  lphs_pkg::entry_t rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  lphs_pkg::entry_t wr_data;

  // Probe evaluation
  logic             is_empty, is_hit, is_tomb, chk_last;
  logic             probe_stop;
  logic [IDX_W-1:0] probe_slot;
  logic             probe_hit, probe_slot_tomb, probe_none;

  // Commit side
  logic             cm_wr;
  lphs_pkg::mark_t  cm_mark;

  logic             req_acc;
  logic [IDX_W-1:0] pos_inc;

  lphs_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (iss_pos_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready   = (state_r == lphs_pkg::S_IDLE);
  assign req_acc    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_rsp    = out_rsp_r;
  assign out_free   = !out_valid_r || out_ready;
  assign sweep_last = (sweep_pos_r == LAST_IDX);
  assign pos_inc    = (iss_pos_r == LAST_IDX) ? '0 : iss_pos_r + 1'b1;

  // Hash reduction: quotient from the reciprocal, then the remainder
  assign mod_prod = (2*KW+1)'(hash_r) * (2*KW+1)'(RECIP_M);
  assign mod_rem  = hash_r - quot_r * DEPTH_K;

  // Read issue: one bucket a cycle until the whole table has been asked for
  assign rd_en = (state_r == lphs_pkg::S_PROBE) && (iss_cnt_r != DEPTH_C);

  // Classify the bucket that has just come back from memory
  always_comb begin
    is_empty   = (rd_data.mark == lphs_pkg::MARK_EMPTY);
    is_tomb    = (rd_data.mark == lphs_pkg::MARK_TOMB);
    is_hit     = (rd_data.mark == lphs_pkg::MARK_OCCUPIED) && (rd_data.item == key_r);
    chk_last   = (chk_cnt_r == LAST_IDX);
    probe_stop = (state_r == lphs_pkg::S_PROBE) && rd_pend_r &&
                 (is_empty || is_hit || chk_last);

    probe_hit       = 1'b0;
    probe_none      = 1'b0;
    probe_slot      = rd_pos_r;
    probe_slot_tomb = 1'b0;
    priority if (is_hit) begin
      probe_hit = 1'b1;
    end else if (is_empty) begin
      if (tomb_seen_r) begin
        probe_slot      = tomb_pos_r;
        probe_slot_tomb = 1'b1;
      end
    end else begin
      // whole table walked: only a tombstone can still be reused
      probe_slot      = tomb_seen_r ? tomb_pos_r : rd_pos_r;
      probe_slot_tomb = 1'b1;
      probe_none      = !(tomb_seen_r || is_tomb);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lphs_pkg::S_INIT: begin
        if (sweep_last) state_nxt = lphs_pkg::S_IDLE;
      end
      lphs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_req.kind == lphs_pkg::KIND_CLEAR) begin
            state_nxt = lphs_pkg::S_CLEAR;
          end else if (IS_POW2) begin
            state_nxt = lphs_pkg::S_PROBE;
          end else begin
            state_nxt = lphs_pkg::S_MOD;
          end
        end
      end
      lphs_pkg::S_MOD: begin
        if (mod_step_r) state_nxt = lphs_pkg::S_PROBE;
      end
      lphs_pkg::S_PROBE: begin
        if (probe_stop) state_nxt = lphs_pkg::S_COMMIT;
      end
      lphs_pkg::S_COMMIT: begin
        if (out_free) state_nxt = lphs_pkg::S_IDLE;
      end
      lphs_pkg::S_CLEAR: begin
        if (sweep_last) state_nxt = lphs_pkg::S_COMMIT;
      end
      default: state_nxt = lphs_pkg::S_IDLE;
    endcase
  end

  // Commit: result, bucket write-back and counter update
  always_comb begin
    cm_wr          = 1'b0;
    cm_mark        = lphs_pkg::MARK_OCCUPIED;
    used_count_nxt = used_count_r;
    tomb_count_nxt = tomb_count_r;
    out_rsp_nxt.status   = lphs_pkg::ST_DONE;
    out_rsp_nxt.found    = 1'b0;
    out_rsp_nxt.item_out = '0;

    if (kind_r != lphs_pkg::KIND_CLEAR) begin
      if (none_r) begin
        out_rsp_nxt.status = lphs_pkg::ST_FULL;
      end else begin
        out_rsp_nxt.found = hit_r;
        unique case (kind_r)
          lphs_pkg::KIND_PUT: begin
            priority if (hit_r) begin
              cm_wr = 1'b1;
            end else if (slot_tomb_r) begin
              cm_wr = 1'b1;
              if (tomb_count_r != '0) tomb_count_nxt = tomb_count_r - 1'b1;
            end else if (used_count_r >= load_limit_r) begin
              out_rsp_nxt.status = lphs_pkg::ST_OVERLOAD;
            end else begin
              cm_wr          = 1'b1;
              used_count_nxt = used_count_r + 1'b1;
            end
          end
          lphs_pkg::KIND_GET: begin
            if (hit_r) out_rsp_nxt.item_out = key_r;
            else       out_rsp_nxt.status   = lphs_pkg::ST_ABSENT;
          end
          lphs_pkg::KIND_REMOVE: begin
            if (hit_r) begin
              cm_wr                = 1'b1;
              cm_mark              = lphs_pkg::MARK_TOMB;
              tomb_count_nxt       = tomb_count_r + 1'b1;
              out_rsp_nxt.item_out = key_r;
            end else begin
              out_rsp_nxt.status = lphs_pkg::ST_ABSENT;
            end
          end
          lphs_pkg::KIND_CLEAR: begin
            out_rsp_nxt.status = lphs_pkg::ST_DONE;
          end
          default: out_rsp_nxt.status = lphs_pkg::ST_DONE;
        endcase
      end
    end
    out_rsp_nxt.used_now = used_count_nxt;

    out_load = (state_r == lphs_pkg::S_COMMIT) && out_free;
    cnt_upd  = out_load || (req_acc && in_req.kind == lphs_pkg::KIND_CLEAR);
  end

  // Memory write port: sweep or commit write-back
  always_comb begin
    if (state_r == lphs_pkg::S_INIT || state_r == lphs_pkg::S_CLEAR) begin
      wr_en        = 1'b1;
      wr_addr      = sweep_pos_r;
      wr_data.mark = lphs_pkg::MARK_EMPTY;
      wr_data.item = '0;
    end else begin
      wr_en        = out_load && cm_wr;
      wr_addr      = slot_r;
      wr_data.mark = cm_mark;
      wr_data.item = key_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lphs_pkg::S_INIT;
      sweep_pos_r  <= '0;
      used_count_r <= '0;
      tomb_count_r <= '0;
      load_limit_r <= lphs_pkg::LOAD_LIMIT_RESET;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;

      if (cfg_we) load_limit_r <= cfg_wdata;

      // sweep address
      if (state_r == lphs_pkg::S_INIT || state_r == lphs_pkg::S_CLEAR) begin
        sweep_pos_r <= sweep_last ? '0 : sweep_pos_r + 1'b1;
      end

      // counters
      if (req_acc && in_req.kind == lphs_pkg::KIND_CLEAR) begin
        used_count_r <= '0;
        tomb_count_r <= '0;
      end else if (out_load) begin
        used_count_r <= used_count_nxt;
        tomb_count_r <= tomb_count_nxt;
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (out_load) out_rsp_r <= out_rsp_nxt;

    // take the request
    if (req_acc) begin
      kind_r     <= in_req.kind;
      key_r      <= in_req.item_key;
      hash_r     <= in_req.hash_value;
      mod_step_r <= 1'b0;
      iss_pos_r  <= in_req.hash_value[IDX_W-1:0];
    end

    // hash reduction: quotient first, then the start bucket from the remainder
    if (state_r == lphs_pkg::S_MOD) begin
      if (!mod_step_r) begin
        quot_r     <= KW'(mod_prod >> RECIP_SH);
        mod_step_r <= 1'b1;
      end else begin
        iss_pos_r <= mod_rem[IDX_W-1:0];
      end
    end

    // probe start
    if (state_r != lphs_pkg::S_PROBE) begin
      iss_cnt_r   <= '0;
      chk_cnt_r   <= '0;
      tomb_seen_r <= 1'b0;
    end

    // probe walk
    if (rd_en) begin
      iss_pos_r <= pos_inc;
      iss_cnt_r <= iss_cnt_r + 1'b1;
      rd_pos_r  <= iss_pos_r;
    end
    if (state_r == lphs_pkg::S_PROBE && rd_pend_r) begin
      chk_cnt_r <= chk_cnt_r + 1'b1;
      if (is_tomb && !tomb_seen_r) begin
        tomb_seen_r <= 1'b1;
        tomb_pos_r  <= rd_pos_r;
      end
    end
    if (probe_stop) begin
      slot_r      <= probe_slot;
      hit_r       <= probe_hit;
      slot_tomb_r <= probe_slot_tomb;
      none_r      <= probe_none;
    end
  end

  // Checks
  a_tomb_within_used: assert property (@(posedge clk) disable iff (!rst_n)
    tomb_count_r <= used_count_r)
    else $error("tombstone count above used count");

  a_overload_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_rsp_nxt.status == lphs_pkg::ST_OVERLOAD) |-> !wr_en)
    else $error("refused put wrote the table");

  a_used_moves_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && used_count_r != $past(used_count_r)) |-> $past(cnt_upd))
    else $error("used count changed outside commit or clear");

endmodule

@@ hw/rtl/lphs_table.sv @@
// ----------------------------------------------------------------------------
// lphs_table
// Bucket memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lphs_table #(
  parameter int unsigned TABLE_DEPTH = lphs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output lphs_pkg::entry_t               rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  lphs_pkg::entry_t               wr_data
);

  lphs_pkg::entry_t mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/hash_set_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_checker
// Watches the request, result and register ports of the hash set. Keeps its
// own copy of the bucket table and counters, works out the response owed for
// every accepted request and compares each accepted result, field by field,
// with the oldest response still owed.
// ----------------------------------------------------------------------------
module hash_set_checker
  import lphs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_req_t            in_req,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_rsp_t           out_rsp,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output int                 errors,
  output int                 outstanding,
  output int                 checked,
  output logic [3:0]         status_seen
);

  // Shadow of the table and its counters
  mark_t              bkt_mark [TABLE_DEPTH];
  logic [KEY_W-1:0]   bkt_key  [TABLE_DEPTH];
  logic [COUNT_W-1:0] used_cnt;
  logic [COUNT_W-1:0] graves_held;
  logic [COUNT_W-1:0] load_lim;

  // Responses owed, oldest first
  out_rsp_t owed_rsp [$];

  task automatic flag(input string what, input logic [KEY_W-1:0] got,
                      input logic [KEY_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void empty_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      bkt_mark[i] = MARK_EMPTY;
    end
    used_cnt    = '0;
    graves_held = '0;
  endfunction

  // Linear probe: slot of an equal key, else first tombstone before the first
  // empty bucket, else that empty bucket; -1 when the walk finds nothing free
  function automatic int locate(input logic [KEY_W-1:0] key,
                                input logic [KEY_W-1:0] hash, output bit hit);
    int pos;
    int tomb;
    pos  = int'(hash % TABLE_DEPTH);
    tomb = -1;
    hit  = 1'b0;
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      if (bkt_mark[pos] == MARK_EMPTY) return (tomb >= 0) ? tomb : pos;
      if (bkt_mark[pos] == MARK_OCCUPIED) begin
        if (bkt_key[pos] == key) begin
          hit = 1'b1;
          return pos;
        end
      end else if (tomb < 0) begin
        tomb = pos;
      end
      pos = int'((pos + 1) % TABLE_DEPTH);
    end
    return tomb;
  endfunction

  // Apply one request to the shadow table and return the response it owes
  function automatic out_rsp_t serve(input in_req_t r);
    out_rsp_t rsp;
    int       slot;
    bit       hit;
    rsp = '0;
    rsp.status = ST_DONE;
    if (r.kind == KIND_CLEAR) begin
      empty_table();
    end else begin
      slot = locate(r.item_key, r.hash_value, hit);
      if (slot < 0) begin
        rsp.status = ST_FULL;
      end else begin
        rsp.found = hit;
        if (r.kind == KIND_PUT) begin
          if (hit) begin
            bkt_key[slot] = r.item_key;
          end else if (bkt_mark[slot] == MARK_TOMB) begin
            bkt_mark[slot] = MARK_OCCUPIED;
            bkt_key[slot]  = r.item_key;
            if (graves_held != 0) graves_held--;
          end else if (used_cnt >= load_lim) begin
            rsp.status = ST_OVERLOAD;
          end else begin
            bkt_mark[slot] = MARK_OCCUPIED;
            bkt_key[slot]  = r.item_key;
            used_cnt++;
          end
        end else if (!hit) begin
          rsp.status = ST_ABSENT;
        end else begin
          rsp.item_out = bkt_key[slot];
          if (r.kind == KIND_REMOVE) begin
            bkt_mark[slot] = MARK_TOMB;
            graves_held++;
          end
        end
      end
    end
    rsp.used_now = used_cnt;
    return rsp;
  endfunction

  // Results are retired before new requests are booked, so a result can
  // never be matched against a request accepted on the same edge
  always @(posedge clk) begin : watch
    out_rsp_t want;
    if (!rst_n) begin
      empty_table();
      load_lim = LOAD_LIMIT_RESET;
      owed_rsp.delete();
      errors      = 0;
      checked     = 0;
      status_seen = '0;
    end else begin
      if (cfg_we) load_lim = cfg_wdata;
      if (out_valid && out_ready) begin
        checked++;
        status_seen[out_rsp.status] = 1'b1;
        if (owed_rsp.size() == 0) begin
          flag("result with no request owed", out_rsp.item_out, '0);
        end else begin
          want = owed_rsp.pop_front();
          if (out_rsp.status !== want.status)
            flag("status", KEY_W'(out_rsp.status), KEY_W'(want.status));
          if (out_rsp.found !== want.found)
            flag("found", KEY_W'(out_rsp.found), KEY_W'(want.found));
          if (out_rsp.item_out !== want.item_out)
            flag("item_out", out_rsp.item_out, want.item_out);
          if (out_rsp.used_now !== want.used_now)
            flag("used_now", KEY_W'(out_rsp.used_now), KEY_W'(want.used_now));
        end
      end
      if (in_valid && in_ready) owed_rsp.push_back(serve(in_req));
    end
    outstanding <= owed_rsp.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the linear-probing hash set: a directed pass over
// empty, wrapped, tombstoned, overloaded and completely full tables, then
// mixed traffic on a small clustered key set under several load limits and
// idling patterns. Checking is done by hash_set_checker.
// ----------------------------------------------------------------------------
module testbench;
  import lphs_pkg::*;

  localparam int unsigned DEPTH     = DEFAULT_TABLE_DEPTH;
  localparam int          POOL      = 64;
  localparam logic [31:0] FILL_BASE = 32'hC000_0000;
  localparam logic [31:0] FRESH     = 32'h0BAD_0000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_req_t            in_req    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_rsp_t           out_rsp;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  int          mismatches;
  int          outstanding;
  int          checked;
  logic [3:0]  status_seen;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 81;
  int          sent = 0;
  int          phase_lim;

  logic [31:0] pool_key  [POOL];
  logic [31:0] pool_hash [POOL];

  linear_probe_hash_set_core #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hash_set_checker #(.TABLE_DEPTH(DEPTH)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .status_seen (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // One request: optional idle cycles, then hold valid until accepted
  task automatic push_req(input kind_t k, input logic [31:0] key, input logic [31:0] h);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{kind: k, item_key: key, hash_value: h};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every owed response has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_load_limit(input logic [COUNT_W-1:0] lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed traffic on the key set, with some random noise
  task automatic mixed_traffic(input int count);
    int roll;
    int idx;
    repeat (count) begin
      roll = $urandom_range(99, 0);
      idx  = $urandom_range(POOL - 1, 0);
      if (roll < 8)
        push_req(kind_t'($urandom_range(3, 0)), $urandom(), $urandom());
      else if (roll < 10)
        push_req(KIND_CLEAR, $urandom(), $urandom());
      else if (roll < 50)
        push_req(KIND_PUT, pool_key[idx], pool_hash[idx]);
      else if (roll < 75)
        push_req(KIND_GET, pool_key[idx], pool_hash[idx]);
      else
        push_req(KIND_REMOVE, pool_key[idx], pool_hash[idx]);
    end
  endtask

  // Give up if the run hangs
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    // homes clustered on the last and first buckets so probes wrap past the end
    for (int i = 0; i < POOL; i++) begin
      pool_key[i]       = $urandom();
      pool_hash[i]      = $urandom();
      pool_hash[i][7:0] = 8'(224 + $urandom_range(47, 0));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, wrap-around, rewrite, tombstones, clear
    push_req(KIND_GET,    32'h0000_0000, 32'h0000_0000);
    push_req(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000);
    push_req(KIND_PUT,    32'h0000_0000, 32'h0000_0000);
    push_req(KIND_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_PUT,    32'h1234_5678, 32'h0000_01FF);
    push_req(KIND_PUT,    32'h1234_5678, 32'h0000_01FF);
    push_req(KIND_GET,    32'h1234_5678, 32'h0000_01FF);
    push_req(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000);
    push_req(KIND_GET,    32'h1234_5678, 32'h0000_01FF);
    push_req(KIND_GET,    32'h0000_0000, 32'h0000_0000);
    push_req(KIND_PUT,    32'hA5A5_A5A5, 32'h0000_0100);
    push_req(KIND_REMOVE, 32'hA5A5_A5A5, 32'h0000_0100);
    push_req(KIND_REMOVE, 32'hA5A5_A5A5, 32'h0000_0100);
    push_req(KIND_PUT,    32'h0000_0000, 32'h0000_0000);
    push_req(KIND_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_CLEAR,  $urandom(), $urandom());
    push_req(KIND_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Directed: load limit refusals, hits and tombstone reuse still allowed
    set_load_limit(9'd3);
    for (int i = 0; i < 3; i++) push_req(KIND_PUT, FRESH + i, 32'd5);
    push_req(KIND_PUT,    FRESH + 3, 32'd5);
    push_req(KIND_PUT,    FRESH + 1, 32'd5);
    push_req(KIND_REMOVE, FRESH + 0, 32'd5);
    push_req(KIND_PUT,    FRESH + 3, 32'd5);
    push_req(KIND_PUT,    FRESH + 4, 32'd5);
    push_req(KIND_CLEAR,  $urandom(), $urandom());

    // Fill every bucket, then probe a table with no free bucket
    set_load_limit(9'd256);
    for (int i = 0; i < DEPTH; i++) push_req(KIND_PUT, FILL_BASE + i, $urandom());
    push_req(KIND_PUT,    FRESH + 16, $urandom());
    push_req(KIND_GET,    FRESH + 16, $urandom());
    push_req(KIND_REMOVE, FRESH + 16, $urandom());
    push_req(KIND_GET,    FILL_BASE + 77, $urandom());
    push_req(KIND_REMOVE, FILL_BASE + 77, $urandom());
    push_req(KIND_PUT,    FRESH + 17, $urandom());
    push_req(KIND_PUT,    FRESH + 18, $urandom());
    push_req(KIND_CLEAR,  $urandom(), $urandom());

    // Mixed traffic: sender idles lightly, receiver stalls heavily
    set_load_limit(9'd511);
    mixed_traffic(120);

    // Roles swapped; tight limits so refusals are common
    send_idle_pct = 81;
    recv_idle_pct = 32;
    set_load_limit(9'd40);
    mixed_traffic(80);
    set_load_limit(9'd0);
    mixed_traffic(20);

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_lim = $urandom_range(200, 16);
    set_load_limit(COUNT_W'(phase_lim));
    mixed_traffic(90);

    drain();
    repeat (DEPTH + 8) @(posedge clk);

    $display("sent %0d requests, checked %0d results; load limits 192, 3, 256, 511, 40, 0, %0d",
             sent, checked, phase_lim);
    $display("status codes seen (overload, full, absent, done): %b", status_seen);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_table.sv
hw/rtl/linear_probe_hash_set_core.sv
tb/hash_set_checker.sv
tb/testbench.sv
